### hdl/sacal_pkg.sv
// ----------------------------------------------------------------------------
// sacal_pkg
// Shared constants, codes and controller/datapath link types of the
// scanned converter range calibrator.
// ----------------------------------------------------------------------------
package sacal_pkg;

  localparam int SCAN_POSITIONS = 8;
  localparam int SAMPLE_BITS    = 12;
  localparam int POS_BITS       = $clog2(SCAN_POSITIONS);
  localparam int POS_FIELD_BITS = 3;
  localparam int BANKS          = 3;
  localparam int CHANNELS       = BANKS + 1;
  localparam int CH_BITS        = $clog2(CHANNELS);
  localparam int STEP_BITS      = 2;
  localparam int CFG_IDX_BITS   = 2;
  localparam int NUM_BITS       = 2 * SAMPLE_BITS;
  localparam int DIV_CNT_BITS   = $clog2(SAMPLE_BITS + 1);

  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};
  localparam logic [POS_BITS-1:0]    LAST_POS   = POS_BITS'(SCAN_POSITIONS - 1);
  localparam logic [CH_BITS-1:0]     LAST_CH    = CH_BITS'(CHANNELS - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_CALIBRATION_STEP = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TONE_RANGE_LOW   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TONE_RANGE_HIGH  = 2'd2;

  // calibration step codes
  localparam logic [STEP_BITS-1:0] STEP_NORMAL   = 2'd0;
  localparam logic [STEP_BITS-1:0] STEP_LOW_REF  = 2'd1;
  localparam logic [STEP_BITS-1:0] STEP_HIGH_REF = 2'd2;
  localparam logic [STEP_BITS-1:0] STEP_LEARN    = 2'd3;

  typedef struct packed {
    logic               load;
    logic               sel_chan;
    logic               range_calc;
    logic               div_start;
    logic               store;
    logic               finish;
    logic [CH_BITS-1:0] channel;
  } sacal_cmd_t;

  typedef struct packed {
    logic div_done;
  } sacal_status_t;

endpackage

### hdl/sacal_in_if.sv
// ----------------------------------------------------------------------------
// sacal_in_if
// Request channel carrying one multiplexer conversion of five raw samples.
// ----------------------------------------------------------------------------
interface sacal_in_if;
  logic                             valid;
  logic                             ready;
  logic [sacal_pkg::SAMPLE_BITS-1:0] raw_tone;
  logic [sacal_pkg::SAMPLE_BITS-1:0] raw_pitch;
  logic [sacal_pkg::SAMPLE_BITS-1:0] raw_bank_one;
  logic [sacal_pkg::SAMPLE_BITS-1:0] raw_bank_two;
  logic [sacal_pkg::SAMPLE_BITS-1:0] raw_bank_three;

  modport source (
    output valid, raw_tone, raw_pitch, raw_bank_one, raw_bank_two, raw_bank_three,
    input  ready
  );
  modport sink (
    input  valid, raw_tone, raw_pitch, raw_bank_one, raw_bank_two, raw_bank_three,
    output ready
  );
endinterface

### hdl/sacal_out_if.sv
// ----------------------------------------------------------------------------
// sacal_out_if
// Result channel carrying the scaled, smoothed and captured channel values.
// ----------------------------------------------------------------------------
interface sacal_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [sacal_pkg::POS_FIELD_BITS-1:0] scan_position;
  logic [sacal_pkg::SAMPLE_BITS-1:0]    tone_level;
  logic [sacal_pkg::SAMPLE_BITS-1:0]    pitch_level;
  logic [sacal_pkg::SAMPLE_BITS-1:0]    bank_one_level;
  logic [sacal_pkg::SAMPLE_BITS-1:0]    bank_two_level;
  logic [sacal_pkg::SAMPLE_BITS-1:0]    bank_three_level;
  logic [sacal_pkg::CHANNELS-1:0]       range_fault;
  logic [sacal_pkg::SAMPLE_BITS-1:0]    low_reference;
  logic [sacal_pkg::SAMPLE_BITS-1:0]    high_reference;

  modport source (
    output valid, scan_position, tone_level, pitch_level, bank_one_level,
           bank_two_level, bank_three_level, range_fault, low_reference,
           high_reference,
    input  ready
  );
  modport sink (
    input  valid, scan_position, tone_level, pitch_level, bank_one_level,
           bank_two_level, bank_three_level, range_fault, low_reference,
           high_reference,
    output ready
  );
endinterface

### hdl/sacal_divider.sv
// ----------------------------------------------------------------------------
// sacal_divider
// Radix-2 restoring divider, one quotient bit per cycle. The numerator's
// upper half must be below the divisor so the quotient fits one sample.
// ----------------------------------------------------------------------------
module sacal_divider (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [sacal_pkg::NUM_BITS-1:0]     num,
  input  logic [sacal_pkg::SAMPLE_BITS-1:0]  den,
  output logic                               done,
  output logic [sacal_pkg::SAMPLE_BITS-1:0]  quotient
);

  logic [sacal_pkg::SAMPLE_BITS-1:0]  rem;
  logic [sacal_pkg::SAMPLE_BITS-1:0]  low_bits;
  logic [sacal_pkg::DIV_CNT_BITS-1:0] cnt;
  logic                               busy;
  logic [sacal_pkg::SAMPLE_BITS:0]    trial;
  logic [sacal_pkg::SAMPLE_BITS:0]    trial_diff;
  logic                               take;

  always_comb begin
    trial      = {rem, low_bits[sacal_pkg::SAMPLE_BITS-1]};
    take       = trial >= {1'b0, den};
    trial_diff = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= sacal_pkg::DIV_CNT_BITS'(sacal_pkg::SAMPLE_BITS);
      done <= 1'b0;
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= cnt != sacal_pkg::DIV_CNT_BITS'(1);
      done <= cnt == sacal_pkg::DIV_CNT_BITS'(1);
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= num[sacal_pkg::NUM_BITS-1:sacal_pkg::SAMPLE_BITS];
      low_bits <= num[sacal_pkg::SAMPLE_BITS-1:0];
    end else if (busy) begin
      rem      <= take ? trial_diff[sacal_pkg::SAMPLE_BITS-1:0]
                       : trial[sacal_pkg::SAMPLE_BITS-1:0];
      low_bits <= {low_bits[sacal_pkg::SAMPLE_BITS-2:0], 1'b0};
      quotient <= {quotient[sacal_pkg::SAMPLE_BITS-2:0], take};
    end
  end

endmodule

### hdl/sacal_datapath.sv
// ----------------------------------------------------------------------------
// sacal_datapath
// Sample inversion, range selection and clamping, shared scaling divider,
// pitch smoothing, reference capture, range learning and result register.
// ----------------------------------------------------------------------------
module sacal_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [sacal_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [sacal_pkg::SAMPLE_BITS-1:0]    cfg_data,
  input  sacal_pkg::sacal_cmd_t                cmd,
  output sacal_pkg::sacal_status_t             status,
  input  logic [sacal_pkg::SAMPLE_BITS-1:0]    raw_tone,
  input  logic [sacal_pkg::SAMPLE_BITS-1:0]    raw_pitch,
  input  logic [sacal_pkg::SAMPLE_BITS-1:0]    raw_bank_one,
  input  logic [sacal_pkg::SAMPLE_BITS-1:0]    raw_bank_two,
  input  logic [sacal_pkg::SAMPLE_BITS-1:0]    raw_bank_three,
  output logic [sacal_pkg::POS_FIELD_BITS-1:0] scan_position,
  output logic [sacal_pkg::SAMPLE_BITS-1:0]    tone_level,
  output logic [sacal_pkg::SAMPLE_BITS-1:0]    pitch_level,
  output logic [sacal_pkg::SAMPLE_BITS-1:0]    bank_one_level,
  output logic [sacal_pkg::SAMPLE_BITS-1:0]    bank_two_level,
  output logic [sacal_pkg::SAMPLE_BITS-1:0]    bank_three_level,
  output logic [sacal_pkg::CHANNELS-1:0]       range_fault,
  output logic [sacal_pkg::SAMPLE_BITS-1:0]    low_reference,
  output logic [sacal_pkg::SAMPLE_BITS-1:0]    high_reference
);

  // configuration
  logic [sacal_pkg::STEP_BITS-1:0]   cal_step;
  logic [sacal_pkg::SAMPLE_BITS-1:0] tone_lo;
  logic [sacal_pkg::SAMPLE_BITS-1:0] tone_hi;

  // persistent state
  logic [sacal_pkg::POS_BITS-1:0]    pos;
  logic [sacal_pkg::SAMPLE_BITS-1:0] pitch_smoothed;
  logic [sacal_pkg::SAMPLE_BITS-1:0] low_capture;
  logic [sacal_pkg::SAMPLE_BITS-1:0] high_capture;
  logic [sacal_pkg::SAMPLE_BITS-1:0] low_tab  [sacal_pkg::BANKS][sacal_pkg::SCAN_POSITIONS];
  logic [sacal_pkg::SAMPLE_BITS-1:0] high_tab [sacal_pkg::BANKS][sacal_pkg::SCAN_POSITIONS];
  logic [sacal_pkg::SCAN_POSITIONS-1:0] tab_valid [sacal_pkg::BANKS];

  // per-request work registers
  logic [sacal_pkg::SAMPLE_BITS-1:0] smp_tone;
  logic [sacal_pkg::SAMPLE_BITS-1:0] smp_pitch;
  logic [sacal_pkg::SAMPLE_BITS-1:0] smp_bank [sacal_pkg::BANKS];
  logic [sacal_pkg::SAMPLE_BITS-1:0] sel_v;
  logic [sacal_pkg::SAMPLE_BITS-1:0] sel_lo;
  logic [sacal_pkg::SAMPLE_BITS-1:0] sel_hi;
  logic [sacal_pkg::SAMPLE_BITS-1:0] diff;
  logic [sacal_pkg::SAMPLE_BITS-1:0] den;
  logic                              fault_cur;
  logic [sacal_pkg::SAMPLE_BITS-1:0] lvl [sacal_pkg::CHANNELS];
  logic [sacal_pkg::CHANNELS-1:0]    flt;

  logic [sacal_pkg::SAMPLE_BITS-1:0] eff_lo [sacal_pkg::BANKS];
  logic [sacal_pkg::SAMPLE_BITS-1:0] eff_hi [sacal_pkg::BANKS];
  logic [sacal_pkg::SAMPLE_BITS-1:0] learn_lo [sacal_pkg::BANKS];
  logic [sacal_pkg::SAMPLE_BITS-1:0] learn_hi [sacal_pkg::BANKS];
  logic [sacal_pkg::BANKS-1:0]       learn_en;
  logic [sacal_pkg::SAMPLE_BITS-1:0] clamped;
  logic [sacal_pkg::NUM_BITS-1:0]    num;
  logic [sacal_pkg::SAMPLE_BITS+2:0] pitch_sum;
  logic [sacal_pkg::SAMPLE_BITS-1:0] pitch_next;
  logic [sacal_pkg::SAMPLE_BITS-1:0] low_capture_next;
  logic [sacal_pkg::SAMPLE_BITS-1:0] high_capture_next;
  logic [sacal_pkg::POS_BITS-1:0]    pos_next;
  logic [sacal_pkg::SAMPLE_BITS-1:0] quotient;

  // untouched table entries read as full scale (low) and zero (high)
  always_comb begin
    for (int b = 0; b < sacal_pkg::BANKS; b++) begin
      eff_lo[b]   = tab_valid[b][pos] ? low_tab[b][pos]  : sacal_pkg::FULL_SCALE;
      eff_hi[b]   = tab_valid[b][pos] ? high_tab[b][pos] : '0;
      learn_lo[b] = (smp_bank[b] < eff_lo[b]) ? smp_bank[b] : eff_lo[b];
      learn_hi[b] = (smp_bank[b] > eff_hi[b]) ? smp_bank[b] : eff_hi[b];
      learn_en[b] = (cal_step == sacal_pkg::STEP_LEARN) &&
                    !((b == sacal_pkg::BANKS - 1) && (pos == sacal_pkg::LAST_POS));
    end
  end

  always_comb begin
    if (sel_v < sel_lo) begin
      clamped = sel_lo;
    end else if (sel_v > sel_hi) begin
      clamped = sel_hi;
    end else begin
      clamped = sel_v;
    end
    // full scale times difference as shift and subtract
    num = {diff, {sacal_pkg::SAMPLE_BITS{1'b0}}} - sacal_pkg::NUM_BITS'(diff);
  end

  always_comb begin
    pitch_sum  = (sacal_pkg::SAMPLE_BITS+3)'({pitch_smoothed, 1'b0}) +
                 (sacal_pkg::SAMPLE_BITS+3)'(pitch_smoothed) +
                 (sacal_pkg::SAMPLE_BITS+3)'(smp_pitch);
    pitch_next = pitch_sum[sacal_pkg::SAMPLE_BITS+1:2];
    low_capture_next  = low_capture;
    high_capture_next = high_capture;
    unique case (cal_step)
      sacal_pkg::STEP_LOW_REF:  low_capture_next  = smp_pitch;
      sacal_pkg::STEP_HIGH_REF: high_capture_next = smp_pitch;
      sacal_pkg::STEP_NORMAL,
      sacal_pkg::STEP_LEARN: ;
      default: ;
    endcase
    pos_next = (pos == sacal_pkg::LAST_POS) ? '0 : pos + 1'b1;
  end

  sacal_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .num      (num),
    .den      (den),
    .done     (status.div_done),
    .quotient (quotient)
  );

  // control-side state
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_step       <= sacal_pkg::STEP_NORMAL;
      tone_lo        <= '0;
      tone_hi        <= sacal_pkg::FULL_SCALE;
      pos            <= '0;
      pitch_smoothed <= '0;
      low_capture    <= '0;
      high_capture   <= '0;
      for (int b = 0; b < sacal_pkg::BANKS; b++) begin
        tab_valid[b] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sacal_pkg::CFG_CALIBRATION_STEP: cal_step <= cfg_data[sacal_pkg::STEP_BITS-1:0];
          sacal_pkg::CFG_TONE_RANGE_LOW:   tone_lo  <= cfg_data;
          sacal_pkg::CFG_TONE_RANGE_HIGH:  tone_hi  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.finish) begin
        pos            <= pos_next;
        pitch_smoothed <= pitch_next;
        low_capture    <= low_capture_next;
        high_capture   <= high_capture_next;
        for (int b = 0; b < sacal_pkg::BANKS; b++) begin
          if (learn_en[b]) begin
            tab_valid[b][pos] <= 1'b1;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_tone    <= ~raw_tone;
      smp_pitch   <= ~raw_pitch;
      smp_bank[0] <= ~raw_bank_one;
      smp_bank[1] <= ~raw_bank_two;
      smp_bank[2] <= ~raw_bank_three;
    end
    if (cmd.sel_chan) begin
      if (cmd.channel == '0) begin
        sel_v  <= smp_tone;
        sel_lo <= tone_lo;
        sel_hi <= tone_hi;
      end else begin
        sel_v  <= smp_bank[cmd.channel - 1'b1];
        sel_lo <= eff_lo[cmd.channel - 1'b1];
        sel_hi <= eff_hi[cmd.channel - 1'b1];
      end
    end
    if (cmd.range_calc) begin
      fault_cur <= sel_hi <= sel_lo;
      diff      <= clamped - sel_lo;
      den       <= sel_hi - sel_lo;
    end
    if (cmd.store) begin
      lvl[cmd.channel] <= fault_cur ? '0 : quotient;
      flt[cmd.channel] <= fault_cur;
    end
    if (cmd.finish) begin
      for (int b = 0; b < sacal_pkg::BANKS; b++) begin
        if (learn_en[b]) begin
          low_tab[b][pos]  <= learn_lo[b];
          high_tab[b][pos] <= learn_hi[b];
        end
      end
      scan_position    <= sacal_pkg::POS_FIELD_BITS'(pos);
      tone_level       <= lvl[0];
      bank_one_level   <= lvl[1];
      bank_two_level   <= lvl[2];
      bank_three_level <= lvl[3];
      range_fault      <= flt;
      pitch_level      <= pitch_next;
      low_reference    <= low_capture_next;
      high_reference   <= high_capture_next;
    end
  end

endmodule

### hdl/sacal_controller.sv
// ----------------------------------------------------------------------------
// sacal_controller
// Sequencer stepping each channel through select, clamp, divide and store,
// then committing the result and holding output valid until taken.
// ----------------------------------------------------------------------------
module sacal_controller (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  output sacal_pkg::sacal_cmd_t    cmd,
  input  sacal_pkg::sacal_status_t status
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_SELECT    = 7'b0000010,
    S_RANGE     = 7'b0000100,
    S_DIV_START = 7'b0001000,
    S_DIV_WAIT  = 7'b0010000,
    S_STORE     = 7'b0100000,
    S_FINISH    = 7'b1000000
  } state_t;

  state_t                         state;
  state_t                         state_next;
  logic [sacal_pkg::CH_BITS-1:0]  channel;
  logic [sacal_pkg::CH_BITS-1:0]  channel_next;
  logic                           out_valid_next;
  logic                           out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    channel_next   = channel;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.channel    = channel;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load     = 1'b1;
          channel_next = '0;
          state_next   = S_SELECT;
        end
      end
      S_SELECT: begin
        cmd.sel_chan = 1'b1;
        state_next   = S_RANGE;
      end
      S_RANGE: begin
        cmd.range_calc = 1'b1;
        state_next     = S_DIV_START;
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (channel == sacal_pkg::LAST_CH) begin
          state_next = S_FINISH;
        end else begin
          channel_next = channel + 1'b1;
          state_next   = S_SELECT;
        end
      end
      S_FINISH: begin
        // wait for the result register to drain
        if (out_free) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      channel   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      channel   <= channel_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### hdl/scanned_adc_range_calibrator.sv
// flow: the four channels are handled in turn; the result commits when its register is free
//   (each channel: select, clamp, divide start, divider iterations, done, store)
// requests are taken one at a time, paced by the shared one-bit-per-cycle divider
// a finished result waits in its output register while the next request is accepted
// reset: synchronous active high; clears control state, counters, captures, table valid bits
// ----------------------------------------------------------------------------
// scanned_adc_range_calibrator
// Scales tone and multiplexed bank samples into learned or configured
// ranges, smooths pitch and captures pitch references.
// ----------------------------------------------------------------------------
module scanned_adc_range_calibrator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sacal_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [sacal_pkg::SAMPLE_BITS-1:0]   cfg_data,
  sacal_in_if.sink                            samples,
  sacal_out_if.source                         levels
);

  sacal_pkg::sacal_cmd_t    cmd;
  sacal_pkg::sacal_status_t status;

  sacal_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (levels.valid),
    .out_ready (levels.ready),
    .cmd       (cmd),
    .status    (status)
  );

  sacal_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .status           (status),
    .raw_tone         (samples.raw_tone),
    .raw_pitch        (samples.raw_pitch),
    .raw_bank_one     (samples.raw_bank_one),
    .raw_bank_two     (samples.raw_bank_two),
    .raw_bank_three   (samples.raw_bank_three),
    .scan_position    (levels.scan_position),
    .tone_level       (levels.tone_level),
    .pitch_level      (levels.pitch_level),
    .bank_one_level   (levels.bank_one_level),
    .bank_two_level   (levels.bank_two_level),
    .bank_three_level (levels.bank_three_level),
    .range_fault      (levels.range_fault),
    .low_reference    (levels.low_reference),
    .high_reference   (levels.high_reference)
  );

endmodule
